@@ design/pdr_pkg.sv @@
// Shared types, constants and requantization tables for the pixel decimate/requantize block.
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int MAX_DIM        = 4096;
  localparam int STEP_FRAC_BITS = 16;
  localparam int DIM_W          = $clog2(MAX_DIM);
  localparam int POS_W          = DIM_W + STEP_FRAC_BITS + 1;
  localparam int RND_W          = DIM_W + 2;
  localparam int CHAN_W         = 8;
  localparam int STEP_W         = 24;
  localparam int BITS_W         = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int IN_DATA_W      = 3 * CHAN_W;
  localparam int OUT_DATA_W     = 3 * CHAN_W + 2 * DIM_W;

  localparam logic [POS_W-1:0] POS_CAP  = POS_W'(MAX_DIM) << STEP_FRAC_BITS;
  localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (STEP_FRAC_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BITS   = 2'd2;

  localparam logic [STEP_W-1:0] DROP_STEP_RST   = 24'd131072;
  localparam logic [BITS_W-1:0] OUTPUT_BITS_RST = 4'd8;

  // ceil(2^24 / (2^b - 1)) for b = 1..8; exact floor division of values below 2^16
  localparam int RQ_SH = 24;
  localparam logic [24:0] RQ_MUL [8] = '{
    25'(((33'd1 << RQ_SH) + 33'd0)   / 33'd1),
    25'(((33'd1 << RQ_SH) + 33'd2)   / 33'd3),
    25'(((33'd1 << RQ_SH) + 33'd6)   / 33'd7),
    25'(((33'd1 << RQ_SH) + 33'd14)  / 33'd15),
    25'(((33'd1 << RQ_SH) + 33'd30)  / 33'd31),
    25'(((33'd1 << RQ_SH) + 33'd62)  / 33'd63),
    25'(((33'd1 << RQ_SH) + 33'd126) / 33'd127),
    25'(((33'd1 << RQ_SH) + 33'd254) / 33'd255)
  };

  typedef struct packed {
    logic              reduce_enable;
    logic [STEP_W-1:0] drop_step;
    logic [BITS_W-1:0] output_bits;
  } cfg_t;

  typedef struct packed {
    logic             keep;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } pos_t;

endpackage

@@ design/pixel_decimate_requantize_top.sv @@
// Top level: row/column decimation with bit-depth requantization of a pixel stream.
//
// Input stream s_*: one pixel per transaction, raster order. s_tdata carries the
// three 8-bit channels, s_tlast marks the last pixel of a row, s_tuser the last
// pixel of the frame (which also ends the row and restarts all counters).
// Output stream m_*: one transaction per kept pixel with the requantized channels
// and its output row and column. Dropped pixels produce no transaction.
// Configuration: cfg_we/cfg_index/cfg_data write reduce_enable (0), drop_step (1),
// output_bits (2); write only while the block is idle.
// Throughput: one pixel per clock while m_tready stays high; the drop decision is one
// position add, saturate and rounding compare on the accepting edge.
// Path: a kept pixel passes the decision register, then the requantization
// multiplier into the output register, before it shows on m_tvalid.
// Reset: rst (synchronous) empties the pipeline, restores register defaults and
// sets the position to row 0, column 0.
// Stall: while m_tready is low the output holds; one more kept pixel can wait in
// the decision register, after which s_tready drops.
`timescale 1ns / 1ps

module pixel_decimate_requantize_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pdr_pkg::IN_DATA_W-1:0]        s_tdata,   // chan_a, chan_b, chan_c
  input  logic                                 s_tlast,   // row_end
  input  logic                                 s_tuser,   // frame_end
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pdr_pkg::OUT_DATA_W-1:0]       m_tdata,   // out_a, out_b, out_c, out_row, out_col
  input  logic                                 cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pdr_pkg::STEP_W-1:0]           cfg_data
);

  pdr_pkg::cfg_t cfg;
  pdr_pkg::pos_t pos;

  logic                           accept;
  logic                           s1_valid;
  logic                           s1_advance;
  logic [pdr_pkg::IN_DATA_W-1:0]  s1_chan;
  logic [pdr_pkg::DIM_W-1:0]      s1_row;
  logic [pdr_pkg::DIM_W-1:0]      s1_col;
  logic [pdr_pkg::CHAN_W-1:0]     rq_a, rq_b, rq_c;
  logic [pdr_pkg::OUT_DATA_W-1:0] m_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reduce_enable <= 1'b0;
      cfg.drop_step     <= pdr_pkg::DROP_STEP_RST;
      cfg.output_bits   <= pdr_pkg::OUTPUT_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdr_pkg::REG_REDUCE_ENABLE: cfg.reduce_enable <= cfg_data[0];
        pdr_pkg::REG_DROP_STEP:     cfg.drop_step     <= cfg_data;
        pdr_pkg::REG_OUTPUT_BITS:   cfg.output_bits   <= cfg_data[pdr_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign accept     = s_tvalid && s_tready;

  pdr_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .row_end   (s_tlast),
    .frame_end (s_tuser),
    .pos       (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && pos.keep) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos.keep) begin
      s1_chan <= s_tdata;
      s1_row  <= pos.row;
      s1_col  <= pos.col;
    end
  end

  pdr_requant u_rq_a (
    .value  (s1_chan[0 +: pdr_pkg::CHAN_W]),
    .bits   (cfg.output_bits),
    .result (rq_a)
  );

  pdr_requant u_rq_b (
    .value  (s1_chan[pdr_pkg::CHAN_W +: pdr_pkg::CHAN_W]),
    .bits   (cfg.output_bits),
    .result (rq_b)
  );

  pdr_requant u_rq_c (
    .value  (s1_chan[2*pdr_pkg::CHAN_W +: pdr_pkg::CHAN_W]),
    .bits   (cfg.output_bits),
    .result (rq_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_data <= {s1_col, s1_row, rq_c, rq_b, rq_a};
    end
  end

  assign m_tdata = m_data;

  a_keep_loads: assert property (@(posedge clk) disable iff (rst)
    accept && pos.keep |=> s1_valid)
    else $error("kept pixel not captured");

  a_no_reduce_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg.reduce_enable |-> pos.keep)
    else $error("pixel dropped with reduction off");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser |=> pos.row == '0 && pos.col == '0)
    else $error("output coordinates not cleared after frame end");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> m_tvalid)
    else $error("output register lost a pixel");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> pos.col == '0)
    else $error("output column not cleared after row end");

endmodule

@@ design/pdr_position.sv @@
// Raster position tracking and row/column drop decision.
`timescale 1ns / 1ps

module pdr_position (
  input  logic          clk,
  input  logic          rst,
  input  pdr_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic          row_end,
  input  logic          frame_end,
  output pdr_pkg::pos_t pos
);

  logic [pdr_pkg::DIM_W-1:0] in_row, in_row_next;
  logic [pdr_pkg::DIM_W-1:0] in_col, in_col_next;
  logic [pdr_pkg::POS_W-1:0] row_drop_pos, row_drop_pos_next;
  logic [pdr_pkg::POS_W-1:0] col_drop_pos, col_drop_pos_next;
  logic [pdr_pkg::DIM_W-1:0] kept_row_count, kept_row_count_next;
  logic [pdr_pkg::DIM_W-1:0] kept_col_count, kept_col_count_next;
  logic                      row_is_dropped, row_is_dropped_next;
  logic                      row_drop, col_drop, keep;

  function automatic logic [pdr_pkg::RND_W-1:0] rnd(input logic [pdr_pkg::POS_W-1:0] p);
    logic [pdr_pkg::POS_W:0] s;
    s = {1'b0, p} + {1'b0, pdr_pkg::POS_HALF};
    return s[pdr_pkg::POS_W:pdr_pkg::STEP_FRAC_BITS];
  endfunction

  function automatic logic [pdr_pkg::POS_W-1:0] adv(input logic [pdr_pkg::POS_W-1:0] p,
                                                    input logic [pdr_pkg::STEP_W-1:0] st);
    logic [pdr_pkg::POS_W:0] n;
    n = {1'b0, p} + (pdr_pkg::POS_W+1)'(st);
    return (n > {1'b0, pdr_pkg::POS_CAP}) ? pdr_pkg::POS_CAP : n[pdr_pkg::POS_W-1:0];
  endfunction

  assign row_drop = cfg.reduce_enable && row_is_dropped;
  assign col_drop = cfg.reduce_enable && !row_drop &&
                    ({2'b00, in_col} == rnd(col_drop_pos));
  assign keep     = !row_drop && !col_drop;

  assign pos.keep = keep;
  assign pos.row  = kept_row_count;
  assign pos.col  = kept_col_count;

  always_comb begin
    col_drop_pos_next   = col_drop ? adv(col_drop_pos, cfg.drop_step) : col_drop_pos;
    kept_col_count_next = keep ? kept_col_count + 1'b1 : kept_col_count;
    in_col_next         = in_col + 1'b1;
    in_row_next         = in_row;
    row_drop_pos_next   = row_drop_pos;
    kept_row_count_next = kept_row_count;
    row_is_dropped_next = row_is_dropped;
    if (frame_end) begin
      in_row_next         = '0;
      in_col_next         = '0;
      row_drop_pos_next   = '0;
      col_drop_pos_next   = '0;
      kept_row_count_next = '0;
      kept_col_count_next = '0;
      row_is_dropped_next = 1'b1;
    end else if (row_end) begin
      if (row_drop) begin
        row_drop_pos_next = adv(row_drop_pos, cfg.drop_step);
      end else begin
        kept_row_count_next = kept_row_count + 1'b1;
      end
      in_row_next         = in_row + 1'b1;
      in_col_next         = '0;
      col_drop_pos_next   = '0;
      kept_col_count_next = '0;
      row_is_dropped_next = ({2'b00, in_row_next} == rnd(row_drop_pos_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row         <= '0;
      in_col         <= '0;
      row_drop_pos   <= '0;
      col_drop_pos   <= '0;
      kept_row_count <= '0;
      kept_col_count <= '0;
      row_is_dropped <= 1'b1;
    end else if (accept) begin
      in_row         <= in_row_next;
      in_col         <= in_col_next;
      row_drop_pos   <= row_drop_pos_next;
      col_drop_pos   <= col_drop_pos_next;
      kept_row_count <= kept_row_count_next;
      kept_col_count <= kept_col_count_next;
      row_is_dropped <= row_is_dropped_next;
    end
  end

endmodule

@@ design/pdr_requant.sv @@
// Per-channel requantization to 2^bits levels (bits clamped to 1..8) rescaled to the 0..255 range.
`timescale 1ns / 1ps

module pdr_requant (
  input  logic [pdr_pkg::CHAN_W-1:0] value,
  input  logic [pdr_pkg::BITS_W-1:0] bits,
  output logic [pdr_pkg::CHAN_W-1:0] result
);

  logic [2:0]  idx;
  logic [7:0]  q;
  logic [15:0] x;
  logic [40:0] prod;

  always_comb begin
    if (bits == '0) begin
      idx = 3'd0;
    end else if (bits > 4'd8) begin
      idx = 3'd7;
    end else begin
      idx = 3'(bits - 4'd1);
    end
  end

  assign q      = value >> (3'd7 - idx);
  assign x      = {q, 8'h00} - {8'h00, q};
  assign prod   = {25'd0, x} * {16'd0, pdr_pkg::RQ_MUL[idx]};
  assign result = prod[pdr_pkg::RQ_SH +: pdr_pkg::CHAN_W];

endmodule

@@ dv/pdr_kept_pixel_check.sv @@
// Checker for the pixel decimate/requantize block: predicts kept pixels and compares them.
`timescale 1ns / 1ps

module pdr_kept_pixel_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [pdr_pkg::IN_DATA_W-1:0]  s_tdata,   // chan_a, chan_b, chan_c
  input  logic                           s_tlast,   // row_end
  input  logic                           s_tuser,   // frame_end
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [pdr_pkg::OUT_DATA_W-1:0] m_tdata,   // out_a, out_b, out_c, out_row, out_col
  input  logic                           cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdr_pkg::STEP_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             pixels_pending,
  output int                             pixels_checked
);
  import pdr_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] c;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
  } kept_pixel_t;

  logic              reduce_en;
  logic [STEP_W-1:0] drop_step;
  logic [BITS_W-1:0] depth;

  logic [DIM_W-1:0]  row_idx, col_idx, kept_rows, kept_cols;
  logic [POS_W-1:0]  row_pos, col_pos;
  logic              row_drop_pending;
  logic              row_gone;

  kept_pixel_t       kept_q[$];
  kept_pixel_t       want, next_px;

  function automatic logic [CHAN_W-1:0] requantize(input logic [CHAN_W-1:0] v,
                                                   input logic [BITS_W-1:0] bits);
    int unsigned b;
    int unsigned q;
    b = bits;
    if (b < 1) b = 1;
    if (b > 8) b = 8;
    q = v >> (8 - b);
    return CHAN_W'((q * 255) / ((1 << b) - 1));
  endfunction

  function automatic int unsigned pos_round(input logic [POS_W-1:0] p);
    return (32'(p) + 32'(POS_HALF)) >> STEP_FRAC_BITS;
  endfunction

  function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] p);
    logic [31:0] n;
    n = 32'(p) + 32'(drop_step);
    return (n > 32'(POS_CAP)) ? POS_CAP : POS_W'(n);
  endfunction

  function automatic int field_err(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  task automatic restart_frame();
    row_idx          = '0;
    col_idx          = '0;
    row_pos          = '0;
    col_pos          = '0;
    kept_rows        = '0;
    kept_cols        = '0;
    row_drop_pending = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reduce_en      = 1'b0;
      drop_step      = DROP_STEP_RST;
      depth          = OUTPUT_BITS_RST;
      restart_frame();
      kept_q.delete();
      mismatches     = 0;
      pixels_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (kept_q.size() == 0) begin
          $error("output transaction with nothing expected: tdata=%h", m_tdata);
          mismatches++;
        end else begin
          want = kept_q.pop_front();
          mismatches += field_err("out_a",   want.a,   m_tdata[7:0])
                      + field_err("out_b",   want.b,   m_tdata[15:8])
                      + field_err("out_c",   want.c,   m_tdata[23:16])
                      + field_err("out_row", want.row, m_tdata[35:24])
                      + field_err("out_col", want.col, m_tdata[47:36]);
          pixels_checked++;
        end
      end

      if (s_tvalid && s_tready) begin
        row_gone = reduce_en && row_drop_pending;
        if (!row_gone) begin
          if (reduce_en && (32'(col_idx) == pos_round(col_pos))) begin
            col_pos = pos_advance(col_pos);
          end else begin
            next_px.a   = requantize(s_tdata[7:0], depth);
            next_px.b   = requantize(s_tdata[15:8], depth);
            next_px.c   = requantize(s_tdata[23:16], depth);
            next_px.row = kept_rows;
            next_px.col = kept_cols;
            kept_q.push_back(next_px);
            kept_cols = kept_cols + 1'b1;
          end
        end
        col_idx = col_idx + 1'b1;

        if (s_tuser) begin
          restart_frame();
        end else if (s_tlast) begin
          if (row_gone) row_pos = pos_advance(row_pos);
          else kept_rows = kept_rows + 1'b1;
          row_idx          = row_idx + 1'b1;
          col_idx          = '0;
          col_pos          = '0;
          kept_cols        = '0;
          row_drop_pending = (32'(row_idx) == pos_round(row_pos));
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_REDUCE_ENABLE: reduce_en = cfg_data[0];
          REG_DROP_STEP:     drop_step = cfg_data;
          REG_OUTPUT_BITS:   depth     = cfg_data[BITS_W-1:0];
          default: ;
        endcase
      end
    end
    pixels_pending = kept_q.size();
  end

endmodule

@@ dv/tb_pixel_decimate_requantize_top.sv @@
// Testbench top: drives pixel frames and register settings into the decimate/requantize block.
`timescale 1ns / 1ps

module tb_pixel_decimate_requantize_top;
  import pdr_pkg::*;

  localparam int IDLE_NONE        = 0;
  localparam int IDLE_SENDER      = 1;
  localparam int IDLE_RECEIVER    = 2;
  localparam int IDLE_BOTH        = 3;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 6;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // chan_a, chan_b, chan_c
  logic                  s_tlast;   // row_end
  logic                  s_tuser;   // frame_end
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // out_a, out_b, out_c, out_row, out_col
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [STEP_W-1:0]     cfg_data;

  int mismatches;
  int pixels_pending;
  int pixels_checked;
  int pixels_sent;
  int frames_sent;
  int settings_used;
  int target;
  int idle_mode;
  bit long_hold;

  pixel_decimate_requantize_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pdr_kept_pixel_check kept_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit stall_roll(input bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender && ($urandom_range(99) < 72);
      IDLE_RECEIVER: return !sender && ($urandom_range(99) < 72);
      IDLE_BOTH:     return $urandom_range(99) < 10;
      default:       return 1'b0;
    endcase
  endfunction

  // receiver; a long hold-off is counted here so the sender keeps offering
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      m_tready <= !stall_roll(1'b0);
    end
  end

  task automatic send_pixel(input logic [IN_DATA_W-1:0] px, input logic row_end,
                            input logic frame_end);
    while (stall_roll(1'b1)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= row_end;
    s_tuser  <= frame_end;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_frame(input int width, input int height, input bit noisy);
    for (int r = 0; r < height; r++) begin
      for (int c = 0; c < width; c++) begin
        if (noisy)
          send_pixel(IN_DATA_W'($urandom), $urandom_range(3) == 0, $urandom_range(15) == 0);
        else
          send_pixel(IN_DATA_W'($urandom), c == width - 1,
                     (c == width - 1) && (r == height - 1));
      end
    end
    frames_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic reduce, input logic [STEP_W-1:0] step_q,
                           input logic [BITS_W-1:0] depth);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_REDUCE_ENABLE;
    cfg_data  <= STEP_W'(reduce);
    @(posedge clk);
    cfg_index <= REG_DROP_STEP;
    cfg_data  <= step_q;
    @(posedge clk);
    cfg_index <= REG_OUTPUT_BITS;
    cfg_data  <= STEP_W'(depth);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    s_tuser       = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_REDUCE_ENABLE;
    cfg_data      = '0;
    idle_mode     = IDLE_NONE;
    long_hold     = 1'b0;
    pixels_sent   = 0;
    frames_sent   = 0;
    settings_used = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: pass-through, extremes of the channels, row and frame end together
    send_pixel(24'h000000, 1'b0, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0);
    send_pixel(24'hC35AA5, 1'b1, 1'b0);
    send_pixel(24'h7F8001, 1'b1, 1'b1);
    // one output bit, drop every other row and column
    configure(1'b1, 24'h020000, 4'd1);
    send_frame(3, 3, 1'b0);
    // zero bit depth and a step below one
    configure(1'b1, 24'h008000, 4'd0);
    send_frame(3, 3, 1'b0);
    // bit depth above eight, reduction off
    configure(1'b0, 24'hFFFFFF, 4'd15);
    send_frame(3, 1, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(1'b1, 24'h010001, 4'd1);
        1: configure(1'b1, 24'hFFFFFF, 4'd8);
        2: configure(1'b0, 24'h020000, 4'd3);
        3: configure(1'b1, 24'h018000, 4'd5);
        default: configure($urandom_range(3) != 0,
                           STEP_W'($urandom_range(24'h050000, 24'h010001)),
                           BITS_W'($urandom_range(8, 1)));
      endcase
      idle_mode = ph % 4;
      if (ph == 2) long_hold = 1'b1;
      target = pixels_sent + 60;
      while (pixels_sent < target)
        send_frame(($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1),
                   $urandom_range(6, 1), $urandom_range(9) == 0);
    end

    drain();
    $display("Sent %0d pixels in %0d frames under %0d register settings.",
             pixels_sent, frames_sent, settings_used);
    $display("Compared %0d kept pixels across idle, stall and back-pressure phases.",
             pixels_checked);
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
